// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared field widths, codes and constants of the text console character
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ENABLE = 2'd2;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

endpackage

// ----- src/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text screen of COLUMNS x ROWS cells with a cursor; writes characters,
// handles control codes, scrolls, clears, moves the cursor and reads cells.
//
//   channel  direction  transaction
//   req      in         command (tuser), char_code, col, row (tdata)
//   rsp      out        cursor state, cell value, scroll flag (tdata)
//   csr      in         fg_color, bg_color, cursor_enable writes
//
// A write that scrolls moves every row up by one: each moved cell is read in
// S_SCROLL_RD and written in S_SCROLL_WR, then the bottom row is blanked.
// After reset the memory is blanked, one cell a cycle, with req_tready low.
// A stalled rsp holds the finished transaction in the output register; the
// next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[1:0]
   input  logic [tcw_pkg::CMD_W-1:0]       req_tuser,
   // char_code[7:0], col[14:8], row[19:15], zero[23:20]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12], cursor_visible[23],
   // cell_value[39:24], scrolled[40], zero[47:41]
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int X_W    = COL_W + 1;

   localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_MAX     = ROW_W'(ROWS - 1);
   localparam logic [X_W-1:0]    COLS_X      = X_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROWS_Y      = ROW_W'(ROWS);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_READ_WAIT,
      S_SCROLL_RD,
      S_SCROLL_WR,
      S_FILL,
      S_DONE
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [COL_W-1:0]     col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [COL_W-1:0]     cur_x_ff;
   logic [ROW_W-1:0]     cur_y_ff;
   logic [ADDR_W-1:0]    idx_ff;
   logic                 scrolled_ff;
   logic [CELL_W-1:0]    cell_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [COLOR_W-1:0]   fg_ff;
   logic [COLOR_W-1:0]   bg_ff;
   logic                 cursor_en_ff;

   logic [COL_W-1:0]     col_in;
   logic [ROW_W-1:0]     row_in;
   logic [CELL_W-1:0]    blank;
   logic [COL_W-1:0]     mul_col;
   logic [ROW_W-1:0]     mul_row;
   logic [ADDR_W-1:0]    addr_unit;

   logic [X_W-1:0]       x_wide;
   logic [X_W-1:0]       tab_sum;
   logic [X_W-1:0]       nx;
   logic [ROW_W-1:0]     ny;
   logic                 ex_we;
   logic [ADDR_W-1:0]    ex_addr;
   logic [CELL_W-1:0]    ex_data;
   logic                 ex_scroll;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign blank = {bg_ff, fg_ff, CH_SPACE};

   assign col_in = (req_tdata[14:8] > COL_MAX) ? COL_MAX : req_tdata[14:8];
   assign row_in = (req_tdata[19:15] > ROW_MAX) ? ROW_MAX : req_tdata[19:15];

   // shared address unit: row * COLUMNS + col
   assign mul_col   = (state_ff == S_EXEC && cmd_ff == CMD_READ) ? col_ff : cur_x_ff;
   assign mul_row   = (state_ff == S_EXEC && cmd_ff == CMD_READ) ? row_ff : cur_y_ff;
   assign addr_unit = ADDR_W'(mul_row) * COLS_A + ADDR_W'(mul_col);

   always_comb begin
      x_wide  = {1'b0, cur_x_ff};
      tab_sum = x_wide + X_W'(4);
      nx      = x_wide;
      ny      = cur_y_ff;
      ex_we   = 1'b0;
      ex_addr = addr_unit;
      ex_data = {bg_ff, fg_ff, char_ff};
      priority if (char_ff == CH_NEWLINE) begin
         nx = '0;
         ny = cur_y_ff + ROW_W'(1);
      end else if (char_ff == CH_RETURN) begin
         nx = '0;
      end else if (char_ff == CH_TAB) begin
         nx = {tab_sum[X_W-1:2], 2'b00};
      end else if (char_ff == CH_BACKSPACE) begin
         if (cur_x_ff != '0) begin
            nx      = x_wide - X_W'(1);
            ex_we   = 1'b1;
            ex_addr = addr_unit - ADDR_W'(1);
            ex_data = blank;
         end
      end else begin
         nx    = x_wide + X_W'(1);
         ex_we = 1'b1;
      end
      if (nx >= COLS_X) begin
         nx = '0;
         ny = ny + ROW_W'(1);
      end
      ex_scroll = (ny >= ROWS_Y);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = blank;
      ram_raddr = addr_unit;
      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_BLANK;
         end
         S_FILL: begin
            ram_we = 1'b1;
         end
         S_EXEC: begin
            if (cmd_ff == CMD_WRITE) begin
               ram_we    = ex_we;
               ram_waddr = ex_addr;
               ram_wdata = ex_data;
            end
         end
         S_SCROLL_RD: begin
            ram_raddr = idx_ff + COLS_A;
         end
         S_SCROLL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   tcw_screen_ram #(
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cursor_en_ff <= 1'b1;
      end else if (csr_we) begin
         if (csr_index == CSR_FG_COLOR) begin
            fg_ff <= csr_wdata[COLOR_W-1:0];
         end
         if (csr_index == CSR_BG_COLOR) begin
            bg_ff <= csr_wdata[COLOR_W-1:0];
         end
         if (csr_index == CSR_CURSOR_ENABLE) begin
            cursor_en_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               idx_ff <= idx_ff + ADDR_W'(1);
               if (idx_ff == CELL_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff      <= cmd_type'(req_tuser);
                  char_ff     <= req_tdata[7:0];
                  col_ff      <= col_in;
                  row_ff      <= row_in;
                  scrolled_ff <= 1'b0;
                  cell_ff     <= '0;
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               unique case (cmd_ff)
                  CMD_WRITE: begin
                     cur_x_ff <= nx[COL_W-1:0];
                     if (ex_scroll) begin
                        cur_y_ff    <= ROW_MAX;
                        scrolled_ff <= 1'b1;
                        idx_ff      <= '0;
                        state_ff    <= S_SCROLL_RD;
                     end else begin
                        cur_y_ff <= ny;
                        state_ff <= S_DONE;
                     end
                  end
                  CMD_CLEAR: begin
                     cur_x_ff <= '0;
                     cur_y_ff <= '0;
                     idx_ff   <= '0;
                     state_ff <= S_FILL;
                  end
                  CMD_SET: begin
                     cur_x_ff <= col_ff;
                     cur_y_ff <= row_ff;
                     state_ff <= S_DONE;
                  end
                  CMD_READ: begin
                     state_ff <= S_READ_WAIT;
                  end
               endcase
            end
            S_READ_WAIT: begin
               cell_ff  <= ram_rdata;
               state_ff <= S_DONE;
            end
            S_SCROLL_RD: begin
               state_ff <= S_SCROLL_WR;
            end
            S_SCROLL_WR: begin
               if (idx_ff == SCROLL_LAST) begin
                  idx_ff   <= BOTTOM_ROW;
                  state_ff <= S_FILL;
               end else begin
                  idx_ff   <= idx_ff + ADDR_W'(1);
                  state_ff <= S_SCROLL_RD;
               end
            end
            S_FILL: begin
               idx_ff <= idx_ff + ADDR_W'(1);
               if (idx_ff == CELL_LAST) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'b0, scrolled_ff, cell_ff, cursor_en_ff,
                                   POS_W'(addr_unit), cur_y_ff, cur_x_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
